// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the null-aware aggregator RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NIA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NIA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/nia_pkg.sv =====
// Types and constants for the null-aware integer aggregator.
// Used by nia_accum and null_aware_integer_aggregator; depends on nothing.
`default_nettype none

package nia_pkg;

	localparam logic [1:0] TYPE_I16 = 2'd0;
	localparam logic [1:0] TYPE_I32 = 2'd1;
	localparam logic [1:0] TYPE_I64 = 2'd2;

	localparam int OUT_COUNT_W = 40;

	localparam logic [63:0] NULL64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] NULL32 = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic        ok;
		logic        last;
		logic [63:0] value;
		logic [63:0] type_null;
	} elem_t;

	typedef struct packed {
		logic [OUT_COUNT_W-1:0] count;
		logic [63:0]            total;
		logic [63:0]            smallest;
		logic [63:0]            largest;
	} res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/null_aware_integer_aggregator.sv =====
// Top level of the null-aware integer aggregator: input stage, type register,
// result register. Depends on nia_pkg, nia_accum and assert_macros.svh.
//
// Usage: column elements arrive on the input channel (in_valid/in_stall) with
// fields value, has_element and last. Each element is decoded with the element
// type in force at its transfer; nulls of the 32- and 64-bit types are skipped.
// A transfer with last set closes the batch and produces one result transfer on
// the output channel (out_valid/out_stall) carrying non_null_count, total,
// smallest and largest. Items without last produce nothing.
// The element type register is written through cfg_we/cfg_wdata. The user
// must write it only while idle; the block itself does not enforce this.
// The result is registered: a last item passes the input stage, then the result
// register. Throughput: one item per cycle while in_stall is low; the 64-bit add
// and the two compares in the accumulator are combinational.
// Reset clears both pipeline valids, the batch state, and sets the type to
// 32-bit. When the receiver stalls, the result stays in the output register;
// non-last items keep flowing, and a last item waits in the input stage, which
// then stalls the sender.
`default_nettype none

`include "assert_macros.svh"

module null_aware_integer_aggregator import nia_pkg::*; #(
	parameter int COUNT_BITS = 40
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_wdata,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [63:0]      value,
	input  wire logic                    has_element,
	input  wire logic                    last,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [OUT_COUNT_W-1:0]       non_null_count,
	output logic signed [63:0]           total,
	output logic signed [63:0]           smallest,
	output logic signed [63:0]           largest
);

	logic [1:0] type_q;
	elem_t      elem_in;
	elem_t      elem_s1;
	logic       valid_s1;
	logic       s1_move;
	res_t       res;
	res_t       res_q;
	logic       out_valid_q;

	always_comb begin
		elem_in.last = last;
		unique case (type_q)
			TYPE_I16: begin
				elem_in.value     = {{48{value[15]}}, value[15:0]};
				elem_in.ok        = has_element;
				elem_in.type_null = NULL32;
			end
			TYPE_I32: begin
				elem_in.value     = {{32{value[31]}}, value[31:0]};
				elem_in.ok        = has_element && (value[31:0] != NULL32[31:0]);
				elem_in.type_null = NULL32;
			end
			default: begin
				elem_in.value     = value;
				elem_in.ok        = has_element && (value != NULL64);
				elem_in.type_null = NULL64;
			end
		endcase
	end

	assign s1_move  = valid_s1 && (!elem_s1.last || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= TYPE_I32;
		end else if (cfg_we) begin
			type_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			elem_s1 <= elem_in;
		end
	end

	nia_accum #(
		.COUNT_BITS(COUNT_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (s1_move),
		.elem   (elem_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move && elem_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && elem_s1.last) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign non_null_count = res_q.count;
	assign total          = res_q.total;
	assign smallest       = res_q.smallest;
	assign largest        = res_q.largest;

	// A held input item must stay in the input stage until it can move on.
	`NIA_ASSERT_NXT(a_s1_hold, valid_s1 && !s1_move, valid_s1,
		"input stage lost a held item")
	// A batch with no counted element always reports a null total.
	`NIA_ASSERT_IMP(a_empty_null, out_valid_q && (res_q.count == '0), res_q.total == NULL64,
		"empty batch did not report a null total")
	// When elements were counted, the minimum never exceeds the maximum.
	`NIA_ASSERT_IMP(a_min_le_max, out_valid_q && (res_q.count != '0),
		$signed(res_q.smallest) <= $signed(res_q.largest),
		"minimum exceeds maximum")

endmodule

`default_nettype wire

// ===== hw/rtl/nia_accum.sv =====
// Batch accumulator: saturating count, wrapping sum, minimum and maximum.
// Depends on nia_pkg; instantiated by null_aware_integer_aggregator.
`default_nettype none

module nia_accum import nia_pkg::*; #(
	parameter int COUNT_BITS = 40
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire elem_t elem,
	output res_t       res
);

	localparam int CW = (COUNT_BITS < OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

	logic [CW-1:0] count_q;
	logic [63:0]   sum_q;
	logic [63:0]   min_q;
	logic [63:0]   max_q;
	logic          seen_q;

	logic [CW-1:0] count_nx;
	logic [63:0]   sum_nx;
	logic [63:0]   min_nx;
	logic [63:0]   max_nx;
	logic          seen_nx;

	always_comb begin
		count_nx = count_q;
		sum_nx   = sum_q;
		min_nx   = min_q;
		max_nx   = max_q;
		seen_nx  = seen_q;
		if (elem.ok) begin
			if (!(&count_q)) begin
				count_nx = count_q + CW'(1);
			end
			sum_nx  = sum_q + elem.value;
			seen_nx = 1'b1;
			if ($signed(elem.value) < $signed(min_q)) begin
				min_nx = elem.value;
			end
			if ($signed(elem.value) > $signed(max_q)) begin
				max_nx = elem.value;
			end
		end
	end

	always_comb begin
		res.count = OUT_COUNT_W'(count_nx);
		if (seen_nx) begin
			res.total    = sum_nx;
			res.smallest = min_nx;
			res.largest  = max_nx;
		end else begin
			res.total    = NULL64;
			res.smallest = elem.type_null;
			res.largest  = elem.type_null;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= MAX64;
			max_q   <= NULL64;
			seen_q  <= 1'b0;
		end else if (take) begin
			if (elem.last) begin
				count_q <= '0;
				sum_q   <= '0;
				min_q   <= MAX64;
				max_q   <= NULL64;
				seen_q  <= 1'b0;
			end else begin
				count_q <= count_nx;
				sum_q   <= sum_nx;
				min_q   <= min_nx;
				max_q   <= max_nx;
				seen_q  <= seen_nx;
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/nia_batch_checker.sv =====
// Checker for the null-aware integer aggregator: watches the configuration port and
// both channels, predicts each batch result and compares it field by field.
// Depends on nia_pkg.
module nia_batch_checker import nia_pkg::*; #(
	parameter int COUNT_BITS = 40
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_wdata,
	input  wire logic                   in_valid,
	input  wire logic                   in_stall,
	input  wire logic [63:0]            value,
	input  wire logic                   has_element,
	input  wire logic                   last,
	input  wire logic                   out_valid,
	input  wire logic                   out_stall,
	input  wire logic [OUT_COUNT_W-1:0] non_null_count,
	input  wire logic [63:0]            total,
	input  wire logic [63:0]            smallest,
	input  wire logic [63:0]            largest,
	output int                          errors,
	output int                          pending
);
	localparam int CAP_W = COUNT_BITS < OUT_COUNT_W ? COUNT_BITS : OUT_COUNT_W;
	localparam logic [OUT_COUNT_W-1:0] COUNT_CAP = {OUT_COUNT_W{1'b1}} >> (OUT_COUNT_W - CAP_W);

	logic [1:0]             elem_type;
	logic [OUT_COUNT_W-1:0] batch_count;
	logic [63:0]            batch_sum;
	logic [63:0]            batch_min;
	logic [63:0]            batch_max;
	logic                   batch_seen;
	res_t                   batch_results_q[$];

	function automatic void open_batch();
		batch_count = '0;
		batch_sum = '0;
		batch_min = MAX64;
		batch_max = NULL64;
		batch_seen = 1'b0;
	endfunction

	function automatic logic [63:0] empty_mark();
		return (elem_type == TYPE_I16 || elem_type == TYPE_I32) ? NULL32 : NULL64;
	endfunction

	function automatic void fold_element(input logic [63:0] raw, input logic has,
			input logic closes);
		logic [63:0] v;
		logic        is_null;
		res_t        r;
		v = raw;
		is_null = 1'b0;
		if (has) begin
			case (elem_type)
				TYPE_I16: v = {{48{raw[15]}}, raw[15:0]};
				TYPE_I32: begin
					v = {{32{raw[31]}}, raw[31:0]};
					is_null = (v == NULL32);
				end
				default: is_null = (raw == NULL64);
			endcase
			if (!is_null) begin
				if (batch_count < COUNT_CAP)
					batch_count = batch_count + 1'b1;
				batch_sum = batch_sum + v;
				if ($signed(v) < $signed(batch_min))
					batch_min = v;
				if ($signed(v) > $signed(batch_max))
					batch_max = v;
				batch_seen = 1'b1;
			end
		end
		if (closes) begin
			r.count = batch_count;
			r.total = batch_seen ? batch_sum : NULL64;
			r.smallest = batch_seen ? batch_min : empty_mark();
			r.largest = batch_seen ? batch_max : empty_mark();
			batch_results_q.push_back(r);
			open_batch();
		end
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] exp,
			input logic [63:0] act);
		if (exp !== act) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			elem_type = TYPE_I32;
			open_batch();
			batch_results_q.delete();
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (batch_results_q.size() == 0) begin
					errors++;
					$display("%0t: result transfer with none expected, expected none, actual %h %h %h %h",
						$time, non_null_count, total, smallest, largest);
				end else begin
					want = batch_results_q.pop_front();
					compare_field("non_null_count", 64'(want.count), 64'(non_null_count));
					compare_field("total", want.total, total);
					compare_field("smallest", want.smallest, smallest);
					compare_field("largest", want.largest, largest);
				end
			end
			if (in_valid && !in_stall)
				fold_element(value, has_element, last);
			if (cfg_we)
				elem_type = cfg_wdata;
		end
		pending = batch_results_q.size();
	end

endmodule

// ===== test/tb.sv =====
// Top of the aggregator testbench: clock, reset, directed and random batches,
// configuration changes between phases and the verdict.
// Depends on nia_pkg, null_aware_integer_aggregator and nia_batch_checker.
module tb;
	import nia_pkg::*;

	localparam logic [1:0] TYPE_SPARE = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [1:0]             cfg_wdata = TYPE_I32;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [63:0]     value = '0;
	logic                   has_element = 1'b0;
	logic                   last = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [OUT_COUNT_W-1:0] non_null_count;
	logic signed [63:0]     total;
	logic signed [63:0]     smallest;
	logic signed [63:0]     largest;
	int                     fail_count;
	int                     open_results;
	bit                     send_gaps = 1'b0;
	bit                     recv_stalls = 1'b0;

	always #5 clk = ~clk;

	null_aware_integer_aggregator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.has_element(has_element), .last(last), .out_valid(out_valid),
		.out_stall(out_stall), .non_null_count(non_null_count), .total(total),
		.smallest(smallest), .largest(largest)
	);

	nia_batch_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .value(value),
		.has_element(has_element), .last(last), .out_valid(out_valid),
		.out_stall(out_stall), .non_null_count(non_null_count), .total(total),
		.smallest(smallest), .largest(largest), .errors(fail_count),
		.pending(open_results)
	);

	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold == 0 && recv_stalls && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 14);
			out_stall = (hold != 0);
			if (hold != 0)
				hold--;
		end
	end

	task automatic push_item(input logic [63:0] v, input logic h, input logic l);
		int gap;
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid = 1'b0;
			value = {$urandom, $urandom};
			has_element = 1'($urandom_range(0, 1));
			last = 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		value = v;
		has_element = h;
		last = l;
		do @(posedge clk); while (in_stall);
	endtask

	// The sender holds off until every result has arrived and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (open_results != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_type(input logic [1:0] t);
		settle();
		cfg_we = 1'b1;
		cfg_wdata = t;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [63:0] pick_value();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return r;
			1: return NULL64;
			2: return MAX64;
			3: return {r[63:32], 32'h8000_0000};
			4: return {r[63:32], 32'h7FFF_FFFF};
			5: return {r[63:16], 16'h8000};
			6: return {r[63:16], 16'h7FFF};
			7: return 64'($urandom_range(0, 200)) - 64'd100;
			8: return NULL64 + 64'd1;
			default: return {{32{r[31]}}, r[31:0]};
		endcase
	endfunction

	initial begin
		logic [1:0] phase_types[8];
		logic       h;
		phase_types = '{TYPE_I16, TYPE_I64, TYPE_I32, TYPE_SPARE, TYPE_I16, TYPE_I64,
			TYPE_I32, 2'd0};
		phase_types[7] = 2'($urandom_range(0, 3));
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		push_item(64'd0, 1'b0, 1'b1);
		push_item(64'h0000_0000_7FFF_FFFF, 1'b1, 1'b0);
		push_item(NULL32, 1'b1, 1'b0);
		push_item(64'h1234_5678_8000_0001, 1'b1, 1'b0);
		push_item(64'hFFFF, 1'b0, 1'b0);
		push_item(64'd5, 1'b1, 1'b1);
		push_item(64'hDEAD_BEEF_8000_0000, 1'b1, 1'b1);

		write_type(TYPE_I16);
		push_item(64'd0, 1'b0, 1'b1);
		push_item(64'hABCD_0123_4567_8000, 1'b1, 1'b0);
		push_item(64'h7FFF, 1'b1, 1'b0);
		push_item(NULL64, 1'b1, 1'b1);

		write_type(TYPE_I64);
		push_item(NULL64, 1'b1, 1'b0);
		push_item(MAX64, 1'b1, 1'b0);
		push_item(MAX64, 1'b1, 1'b0);
		push_item(NULL64 + 64'd1, 1'b1, 1'b0);
		push_item(-64'sd1, 1'b1, 1'b1);

		write_type(TYPE_SPARE);
		push_item(NULL64, 1'b1, 1'b1);
		push_item(64'd0, 1'b0, 1'b1);

		// A type change inside a batch keeps the batch and applies to later elements.
		write_type(TYPE_I32);
		push_item(64'h0000_0001_0000_0001, 1'b1, 1'b0);
		write_type(TYPE_I16);
		push_item(64'h0000_0000_0001_0002, 1'b1, 1'b1);
		write_type(TYPE_I64);
		push_item(NULL64, 1'b1, 1'b0);
		write_type(TYPE_I16);
		push_item(64'd0, 1'b0, 1'b1);

		for (int ph = 0; ph < 8; ph++) begin
			write_type(phase_types[ph]);
			send_gaps = (ph < 7) && (ph % 3 != 1);
			recv_stalls = (ph < 7) && (ph % 3 != 2);
			for (int i = 0; i < 180; i++) begin
				h = ($urandom_range(0, 7) != 0);
				push_item(h ? pick_value() : {$urandom, $urandom}, h,
					$urandom_range(0, 5) == 0);
			end
		end
		push_item(pick_value(), 1'b1, 1'b1);

		@(negedge clk);
		in_valid = 1'b0;
		while (open_results != 0) @(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("PASS null_aware_integer_aggregator");
		else
			$display("FAIL null_aware_integer_aggregator");
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL null_aware_integer_aggregator");
		$finish;
	end

endmodule
